[sv/assert_macros.svh]
// Assertion macros shared by the character range expander RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that prop holds at every rising edge outside reset.
`define CRX_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("crx assertion failed");

// Check that cond never holds at a rising edge outside reset.
`define CRX_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("crx forbidden condition seen");

`else

`define CRX_ASSERT(lbl, clk, rst_n, prop)
`define CRX_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

[sv/crx_pkg.sv]
// Types and constants shared by the character range expander modules.
`default_nettype none

package crx_pkg;

    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_LOW_A = 8'h61;
    localparam logic [7:0] CHAR_LOW_Z = 8'h7A;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CASE_GAP   = 8'h20;

    // Longest run of characters strictly between two range ends (a to z).
    localparam int RUN_MAX = 24;
    localparam int RUN_W   = $clog2(RUN_MAX + 1);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0] in_char;
        logic       in_final;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_last;
        logic       text_end;
    } out_beat_t;

    // One classified item: a run of run_count characters starting at
    // run_first and stepping up or down, then the tail character.
    typedef struct packed {
        logic [7:0]       run_first;
        logic [RUN_W-1:0] run_count;
        logic             run_down;
        logic [7:0]       tail_char;
        logic             fin;
    } crx_cmd_t;

    function automatic logic is_lower(input logic [7:0] c);
        return (c >= CHAR_LOW_A) && (c <= CHAR_LOW_Z);
    endfunction

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= CHAR_UP_A) && (c <= CHAR_UP_Z);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

endpackage

`default_nettype wire

[sv/char_range_expander.sv]
// Top level of the character range expander.
`default_nettype none

// Expands range shorthand such as a-f, Z-T or 0-9 in a stream of ASCII
// characters, one character per input beat, with in_final marking the last
// character of a string. A dash between two letters yields the letters
// strictly between them, ascending or descending, in the case of the first
// letter, followed by the second character as given; two digits around a dash
// work the same way. Any other dash, leading or trailing, comes out literally.
// A dash that is not final yields nothing on its own beat: it is held until
// the next character decides it. Each result beat carries run_last on the
// last character caused by its input beat and text_end on the last character
// of the string. An ordinary character yields one result beat and an expanded
// range its run plus the tail, up to 25 result beats; the emitter produces at
// most one result beat per cycle, none while res_stall holds a valid one. The
// front end classifies input beats as they arrive and parks them in a two-entry
// queue, so input keeps flowing while a range is being written out until the
// queue fills. The first result beat of an input beat goes through a queue slot
// and then the output register before res_valid shows it. There are no
// configuration registers.

module char_range_expander
    import crx_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     item_valid,
    output logic          item_stall,
    input  wire in_beat_t item,
    output logic          res_valid,
    input  wire logic     res_stall,
    output out_beat_t     res
);

    logic      q_full;
    logic      push;
    crx_cmd_t  push_cmd;
    logic      pop;
    logic      head_valid;
    crx_cmd_t  head;

    // Hold input only while the queue has no room.
    assign item_stall = q_full;

    crx_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .q_full     (q_full),
        .push       (push),
        .cmd        (push_cmd)
    );

    crx_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head)
    );

    crx_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res)
    );

endmodule

`default_nettype wire

[sv/crx_front.sv]
// Front end: tracks the previous character and held dash, classifies each beat.
`default_nettype none

`include "assert_macros.svh"

module crx_front
    import crx_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     item_valid,
    input  wire in_beat_t item,
    input  wire logic     q_full,
    output logic          push,
    output crx_cmd_t      cmd
);

    logic [7:0] prior_char_reg, prior_char_next;
    logic       dash_held_reg, dash_held_next;
    logic [7:0] before_dash_reg, before_dash_next;

    logic       accept;
    logic       is_dash;
    logic [7:0] c;
    logic [7:0] lo;
    logic       c_alpha;
    logic       lo_alpha;
    logic       in_range;
    logic [7:0] tgt;
    logic       up;
    logic [7:0] gap;
    logic [7:0] run_len;

    assign c       = item.in_char;
    assign lo      = before_dash_reg;
    assign is_dash = (c == CHAR_DASH);
    assign accept  = item_valid && !q_full;

    assign c_alpha  = is_lower(c) || is_upper(c);
    assign lo_alpha = is_lower(lo) || is_upper(lo);
    assign in_range = dash_held_reg &&
                      ((lo_alpha && c_alpha) || (is_digit(lo) && is_digit(c)));

    // Fold the right end into the case of the left end.
    always_comb
    begin
        priority if (is_lower(lo) && is_upper(c))
            tgt = c + CASE_GAP;
        else if (is_upper(lo) && is_lower(c))
            tgt = c - CASE_GAP;
        else
            tgt = c;
    end

    assign up      = (lo <= tgt);
    assign gap     = up ? (tgt - lo) : (lo - tgt);
    assign run_len = (gap == 8'd0) ? 8'd0 : (gap - 8'd1);

    always_comb
    begin
        cmd.tail_char = c;
        cmd.fin       = item.in_final;
        cmd.run_down  = 1'b0;
        cmd.run_first = CHAR_DASH;
        cmd.run_count = '0;
        if (is_dash) begin
            // A held dash meeting a final dash goes out literally ahead of it.
            push = dash_held_reg || item.in_final;
            if (dash_held_reg && item.in_final)
                cmd.run_count = RUN_W'(1);
        end
        else begin
            push = 1'b1;
            priority if (in_range)
            begin
                cmd.run_first = up ? (lo + 8'd1) : (lo - 8'd1);
                cmd.run_count = run_len[RUN_W-1:0];
                cmd.run_down  = !up;
            end
            else if (dash_held_reg)
                cmd.run_count = RUN_W'(1);
            else
                cmd.run_count = '0;
        end
        push = push && accept;
    end

    always_comb
    begin
        prior_char_next  = prior_char_reg;
        dash_held_next   = dash_held_reg;
        before_dash_next = before_dash_reg;
        if (accept) begin
            if (item.in_final) begin
                prior_char_next  = '0;
                dash_held_next   = 1'b0;
                before_dash_next = '0;
            end
            else begin
                prior_char_next = c;
                dash_held_next  = is_dash;
                if (is_dash)
                    before_dash_next = prior_char_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            prior_char_reg  <= '0;
            dash_held_reg   <= 1'b0;
            before_dash_reg <= '0;
        end
        else begin
            prior_char_reg  <= prior_char_next;
            dash_held_reg   <= dash_held_next;
            before_dash_reg <= before_dash_next;
        end
    end

    `CRX_ASSERT(a_held_dash_is_prior, clk, rst_n,
        dash_held_reg |-> (prior_char_reg == CHAR_DASH))
    `CRX_ASSERT(a_run_bounded, clk, rst_n,
        push |-> (cmd.run_count <= RUN_W'(RUN_MAX)))

endmodule

`default_nettype wire

[sv/crx_queue.sv]
// Short command queue between the front end and the emitter.
`default_nettype none

`include "assert_macros.svh"

module crx_queue
    import crx_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire crx_cmd_t push_cmd,
    input  wire logic     pop,
    output logic          full,
    output logic          head_valid,
    output crx_cmd_t      head
);

    crx_cmd_t            slot_reg [QDEPTH];
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QDEPTH - 1)) ? '0 : (p + 1'b1);
    endfunction

    assign full       = (cnt_reg == QCNT_W'(QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    `CRX_NEVER(a_no_push_when_full, clk, rst_n, push && full)
    `CRX_NEVER(a_no_pop_when_empty, clk, rst_n, pop && !head_valid)

endmodule

`default_nettype wire

[sv/crx_back.sv]
// Back end: walks each command's run and tail into the output register.
`default_nettype none

`include "assert_macros.svh"

module crx_back
    import crx_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     head_valid,
    input  wire crx_cmd_t head,
    output logic          pop,
    output logic          res_valid,
    input  wire logic     res_stall,
    output out_beat_t     res
);

    logic             busy_reg, busy_next;
    crx_cmd_t         cur_reg, cur_next;
    logic             ovalid_reg, ovalid_next;
    out_beat_t        obeat_reg, obeat_next;

    crx_cmd_t         src;
    logic             src_valid;
    logic             adv;

    // Work from the held command while busy, else straight from the queue head.
    assign src       = busy_reg ? cur_reg : head;
    assign src_valid = busy_reg || head_valid;
    assign adv       = src_valid && (!ovalid_reg || !res_stall);
    assign pop       = adv && !busy_reg;

    always_comb
    begin
        busy_next  = busy_reg;
        cur_next   = cur_reg;
        obeat_next = obeat_reg;
        ovalid_next = ovalid_reg && res_stall;
        if (adv) begin
            ovalid_next = 1'b1;
            if (src.run_count != '0) begin
                obeat_next.out_char = src.run_first;
                obeat_next.run_last = 1'b0;
                obeat_next.text_end = 1'b0;
                busy_next           = 1'b1;
                cur_next            = src;
                cur_next.run_first  = src.run_down ? (src.run_first - 8'd1)
                                                   : (src.run_first + 8'd1);
                cur_next.run_count  = src.run_count - 1'b1;
            end
            else begin
                obeat_next.out_char = src.tail_char;
                obeat_next.run_last = 1'b1;
                obeat_next.text_end = src.fin;
                busy_next           = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else begin
            busy_reg   <= busy_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        obeat_reg <= obeat_next;
    end

    assign res_valid = ovalid_reg;
    assign res       = obeat_reg;

    `CRX_ASSERT(a_end_only_on_last, clk, rst_n,
        (ovalid_reg && !obeat_reg.run_last) |-> !obeat_reg.text_end)
    `CRX_ASSERT(a_busy_run_bounded, clk, rst_n,
        busy_reg |-> (cur_reg.run_count < RUN_W'(RUN_MAX)))

endmodule

`default_nettype wire
